[src/programmable_crc_unit_defines.svh]
// assertion macros for the programmable crc unit checker
`ifndef PROGRAMMABLE_CRC_UNIT_DEFINES_SVH
`define PROGRAMMABLE_CRC_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PCRC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PCRC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/pcrc_pkg.sv]
// types, codes, reset values and bit functions of the programmable crc unit
package pcrc_pkg;

    localparam int CRC_W = 32;
    localparam int CFG_IDX_W = 3;

    // polynomial size codes
    localparam logic [1:0] PSZ_32 = 2'd0;
    localparam logic [1:0] PSZ_16 = 2'd1;
    localparam logic [1:0] PSZ_8  = 2'd2;
    localparam logic [1:0] PSZ_7  = 2'd3;

    // write width codes, code three acts as a word
    localparam logic [1:0] WW_BYTE = 2'd0;
    localparam logic [1:0] WW_HALF = 2'd1;
    localparam logic [1:0] WW_WORD = 2'd2;

    // commands
    localparam logic CMD_RELOAD = 1'b0;
    localparam logic CMD_FEED   = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POLY_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLYNOMIAL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_VALUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FINAL_XOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REFLECT_IN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REFLECT_OUT = 3'd5;

    // reset values
    localparam logic [1:0]       POLY_SIZE_RST   = PSZ_32;
    localparam logic [CRC_W-1:0] POLYNOMIAL_RST  = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0] INIT_VALUE_RST  = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] FINAL_XOR_RST   = 32'hFFFF_FFFF;
    localparam logic             REFLECT_IN_RST  = 1'b1;
    localparam logic             REFLECT_OUT_RST = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [1:0]       write_width;
        logic [CRC_W-1:0] write_data;
    } in_beat_t;

    function automatic logic [CRC_W-1:0] poly_mask(input logic [1:0] code);
        logic [CRC_W-1:0] m;
        case (code)
            PSZ_32:  m = 32'hFFFF_FFFF;
            PSZ_16:  m = 32'h0000_FFFF;
            PSZ_8:   m = 32'h0000_00FF;
            default: m = 32'h0000_007F;
        endcase
        return m;
    endfunction

    function automatic logic [4:0] poly_top(input logic [1:0] code);
        logic [4:0] t;
        case (code)
            PSZ_32:  t = 5'd31;
            PSZ_16:  t = 5'd15;
            PSZ_8:   t = 5'd7;
            default: t = 5'd6;
        endcase
        return t;
    endfunction

    function automatic logic [CRC_W-1:0] rev32(input logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] r;
        for (int i = 0; i < CRC_W; i++) begin
            r[i] = v[CRC_W-1-i];
        end
        return r;
    endfunction

    // eight serial crc steps, msb of the byte first
    function automatic logic [CRC_W-1:0] crc_byte(
        input logic [CRC_W-1:0] crc,
        input logic [7:0]       b,
        input logic [CRC_W-1:0] poly,
        input logic [CRC_W-1:0] pmask,
        input logic [4:0]       top
    );
        logic [CRC_W-1:0] c;
        logic             fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[top] ^ b[i];
            c  = (c << 1) & pmask;
            if (fb) begin
                c = c ^ poly;
            end
        end
        return c;
    endfunction

endpackage

[src/programmable_crc_unit.sv]
// programmable crc unit: input register, crc update network, result register
//
//  channel   | ports                      | beat contents
//  ----------+----------------------------+-------------------------------------
//  input     | s_tvalid s_tready s_tdata  | tdata: write_data; tuser: cmd,
//            | s_tuser                    | write_width
//  result    | m_tvalid m_tready m_tdata  | tdata: crc_raw, crc_final
//  config    | cfg_wr_en cfg_index        | cfg_wdata: register value
//            | cfg_wdata                  |
//
// one beat per cycle unless the result channel stalls
// the remainder register closes a loop through a 32-step xor network
// reset loads the config registers and the remainder from their reset values
// a stalled result holds in the result register while one more beat waits
// in the input register
module programmable_crc_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // write_data
    input  logic [2:0]                      s_tuser,   // cmd, write_width[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [63:0]                     m_tdata,   // crc_raw, crc_final
    input  logic                            cfg_wr_en,
    input  logic [pcrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_wdata
);

    logic [1:0]  poly_size_reg;
    logic [31:0] polynomial_reg;
    logic [31:0] init_value_reg;
    logic [31:0] final_xor_reg;
    logic        reflect_in_reg;
    logic        reflect_out_reg;
    logic [31:0] remainder_reg;
    logic [31:0] remainder_next;

    logic               in_vld_reg;
    pcrc_pkg::in_beat_t in_reg;
    logic               out_vld_reg;
    logic [31:0]        raw_reg;
    logic [31:0]        final_reg;

    logic        advance;
    logic [31:0] pmask;
    logic [4:0]  top;
    logic [31:0] poly;
    logic [31:0] data_m;
    logic [31:0] data_r;
    logic [31:0] crc_cur;
    logic [31:0] crc_new;
    logic [31:0] raw_next;

    assign advance  = !out_vld_reg || m_tready;
    assign s_tready = !in_vld_reg || advance;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {final_reg, raw_reg};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_size_reg   <= pcrc_pkg::POLY_SIZE_RST;
            polynomial_reg  <= pcrc_pkg::POLYNOMIAL_RST;
            init_value_reg  <= pcrc_pkg::INIT_VALUE_RST;
            final_xor_reg   <= pcrc_pkg::FINAL_XOR_RST;
            reflect_in_reg  <= pcrc_pkg::REFLECT_IN_RST;
            reflect_out_reg <= pcrc_pkg::REFLECT_OUT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pcrc_pkg::REG_POLY_SIZE:   poly_size_reg   <= cfg_wdata[1:0];
                pcrc_pkg::REG_POLYNOMIAL:  polynomial_reg  <= cfg_wdata;
                pcrc_pkg::REG_INIT_VALUE:  init_value_reg  <= cfg_wdata;
                pcrc_pkg::REG_FINAL_XOR:   final_xor_reg   <= cfg_wdata;
                pcrc_pkg::REG_REFLECT_IN:  reflect_in_reg  <= cfg_wdata[0];
                pcrc_pkg::REG_REFLECT_OUT: reflect_out_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // crc update
    always_comb begin
        pmask   = pcrc_pkg::poly_mask(poly_size_reg);
        top     = pcrc_pkg::poly_top(poly_size_reg);
        poly    = polynomial_reg & pmask;
        crc_cur = remainder_reg & pmask;

        case (in_reg.write_width)
            pcrc_pkg::WW_BYTE: begin
                data_m = {24'd0, in_reg.write_data[7:0]};
                data_r = pcrc_pkg::rev32(data_m) >> 24;
            end
            pcrc_pkg::WW_HALF: begin
                data_m = {16'd0, in_reg.write_data[15:0]};
                data_r = pcrc_pkg::rev32(data_m) >> 16;
            end
            default: begin
                data_m = in_reg.write_data;
                data_r = pcrc_pkg::rev32(data_m);
            end
        endcase
        if (reflect_in_reg) begin
            data_m = data_r;
        end

        crc_new = crc_cur;
        if (in_reg.write_width != pcrc_pkg::WW_BYTE &&
            in_reg.write_width != pcrc_pkg::WW_HALF) begin
            crc_new = pcrc_pkg::crc_byte(crc_new, data_m[31:24], poly, pmask, top);
            crc_new = pcrc_pkg::crc_byte(crc_new, data_m[23:16], poly, pmask, top);
        end
        if (in_reg.write_width != pcrc_pkg::WW_BYTE) begin
            crc_new = pcrc_pkg::crc_byte(crc_new, data_m[15:8], poly, pmask, top);
        end
        crc_new = pcrc_pkg::crc_byte(crc_new, data_m[7:0], poly, pmask, top);

        if (in_reg.cmd == pcrc_pkg::CMD_RELOAD) begin
            crc_new = init_value_reg & pmask;
        end

        remainder_next = remainder_reg;
        if (in_vld_reg && advance) begin
            remainder_next = crc_new;
        end

        raw_next = crc_new;
        if (reflect_out_reg) begin
            case (poly_size_reg)
                pcrc_pkg::PSZ_32: raw_next = pcrc_pkg::rev32(crc_new);
                pcrc_pkg::PSZ_16: raw_next = pcrc_pkg::rev32(crc_new) >> 16;
                pcrc_pkg::PSZ_8:  raw_next = pcrc_pkg::rev32(crc_new) >> 24;
                default:          raw_next = pcrc_pkg::rev32(crc_new) >> 25;
            endcase
        end
    end

    // control state and remainder
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remainder_reg <= pcrc_pkg::INIT_VALUE_RST;
            in_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
        end else begin
            remainder_reg <= remainder_next;
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (advance) begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.cmd         <= s_tuser[0];
            in_reg.write_width <= s_tuser[2:1];
            in_reg.write_data  <= s_tdata;
        end
        if (in_vld_reg && advance) begin
            raw_reg   <= raw_next;
            final_reg <= raw_next ^ final_xor_reg;
        end
    end

endmodule

[src/pcrc_checker.sv]
// port-level checker for the programmable crc unit and its bind
`include "programmable_crc_unit_defines.svh"

module pcrc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [63:0]                     m_tdata,
    input logic                            cfg_wr_en,
    input logic [pcrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [31:0]                     cfg_wdata
);

    logic [1:0]  size_reg;
    logic [31:0] fxor_reg;
    logic        in_beat;

    assign in_beat = s_tvalid && s_tready;

    // shadow of the registers the result beats depend on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= pcrc_pkg::POLY_SIZE_RST;
            fxor_reg <= pcrc_pkg::FINAL_XOR_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == pcrc_pkg::REG_POLY_SIZE) begin
                size_reg <= cfg_wdata[1:0];
            end
            if (cfg_index == pcrc_pkg::REG_FINAL_XOR) begin
                fxor_reg <= cfg_wdata;
            end
        end
    end

    `PCRC_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    `PCRC_ASSERT_IMP(a_out_from_in, aclk, aresetn, $rose(m_tvalid),
        $past(in_beat, 2), "result beat without matching input beat")

    `PCRC_ASSERT_IMP(a_final_mask, aclk, aresetn, m_tvalid,
        (m_tdata[63:32] ^ m_tdata[31:0]) == fxor_reg, "final crc not raw xor mask")

    `PCRC_ASSERT_IMP(a_raw_width, aclk, aresetn, m_tvalid,
        (m_tdata[31:0] & ~pcrc_pkg::poly_mask(size_reg)) == 32'd0,
        "raw crc wider than polynomial")

endmodule

bind programmable_crc_unit pcrc_checker u_pcrc_checker (.*);
